FILE: rtl/core/leakage_test_ramp_sequencer_defines.svh
// Assertion macros shared by the leakage test ramp sequencer RTL.
`ifndef LEAKAGE_TEST_RAMP_SEQUENCER_DEFINES_SVH
`define LEAKAGE_TEST_RAMP_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define LTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define LTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/lts_pkg.sv
// Types, constants and register codes of the leakage test ramp sequencer.
package lts_pkg;

  localparam int VOLT_W   = 16;
  localparam int CUR_W    = 16;
  localparam int COUNT_W  = 16;
  localparam int LVL_W    = 15;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Default tolerance of the short check, in percent of the short level.
  localparam int SHORT_TOLERANCE_PERCENT_DEF = 10;
  // Scale that turns a current difference into percent units.
  localparam int NEAR_SCALE = 100;

  // Command codes of an input beat.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Run status codes.
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_RUN     = 3'd1,
    ST_DONE    = 3'd2,
    ST_SHORT   = 3'd3,
    ST_NODEV   = 3'd4,
    ST_TIMEOUT = 3'd5
  } status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_VOLTAGE   = 3'd0,
    CFG_RAMP_STEP     = 3'd1,
    CFG_SAMPLE_TOTAL  = 3'd2,
    CFG_SHORT_LEVEL   = 3'd3,
    CFG_DEV_CHECK_EN  = 3'd4,
    CFG_EMULATED      = 3'd5,
    CFG_SYNC_DELAY    = 3'd6,
    CFG_SYNC_TIMEOUT  = 3'd7
  } cfg_reg_t;

  // Register reset values.
  localparam logic [VOLT_W-1:0]  SET_VOLTAGE_RST  = 16'd0;
  localparam logic [VOLT_W-1:0]  RAMP_STEP_RST    = 16'd1;
  localparam logic [COUNT_W-1:0] SAMPLE_TOTAL_RST = 16'd1;
  localparam logic [LVL_W-1:0]   SHORT_LEVEL_RST  = 15'd32767;
  localparam logic [COUNT_W-1:0] SYNC_DELAY_RST   = 16'd25;
  localparam logic [COUNT_W-1:0] SYNC_TIMEOUT_RST = 16'd100;

  typedef struct packed {
    logic [VOLT_W-1:0]  set_voltage;
    logic [VOLT_W-1:0]  ramp_step;
    logic [COUNT_W-1:0] sample_total;
    logic [LVL_W-1:0]   short_current_level;
    logic               device_check_enable;
    logic               emulated_partner;
    logic [COUNT_W-1:0] sync_delay_ticks;
    logic [COUNT_W-1:0] sync_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic                    command;
    logic signed [CUR_W-1:0] sample_current;
    logic                    sync_event;
    logic                    ms_strobe;
  } item_t;

  typedef struct packed {
    logic [VOLT_W-1:0] voltage_target;
    logic              on_plateau;
    logic              sync_out;
    logic              input_shorted;
    status_t           run_status;
  } result_t;

endpackage

FILE: rtl/core/lts_engine.sv
// Run state and one-beat update of the ramp, device check and sync counting.
module lts_engine
  import lts_pkg::*;
#(
  parameter int SHORT_TOLERANCE_PERCENT = SHORT_TOLERANCE_PERCENT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step_en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  `include "leakage_test_ramp_sequencer_defines.svh"

  localparam int DIFF_W = CUR_W + 2;
  localparam int MAG_W  = DIFF_W - 1;
  localparam int CMP_W  = MAG_W + $clog2(NEAR_SCALE + 1);
  localparam int LIM_W  = LVL_W + $clog2(SHORT_TOLERANCE_PERCENT + 1);

  // Run state.
  logic                      running, running_next;
  logic                      plateau_flag, plateau_next;
  logic                      device_checked, device_checked_next;
  logic                      sync_pending, sync_pending_next;
  logic                      sync_level, sync_level_next;
  logic                      short_held, short_held_next;
  logic [VOLT_W-1:0]         target_now, target_next;
  logic [COUNT_W-1:0]        samples_left, samples_next;
  logic [COUNT_W-1:0]        samples_seen, samples_seen_next;
  logic [COUNT_W-1:0]        delay_left, delay_next;
  logic [COUNT_W-1:0]        stall_ms, stall_next;
  logic signed [CUR_W-1:0]   peak_current, peak_next;
  status_t                   status, status_next;

  logic                      check_ok;
  logic                      sync_ok;
  logic [VOLT_W:0]           target_sum;
  logic [VOLT_W-1:0]         target_sat;
  logic [COUNT_W-1:0]        samples_dec;
  logic signed [DIFF_W-1:0]  level_s;
  logic signed [DIFF_W-1:0]  peak_diff;
  logic signed [DIFF_W-1:0]  cur_diff;
  logic [CMP_W-1:0]          peak_scaled;
  logic [CMP_W-1:0]          cur_scaled;
  logic [LIM_W-1:0]          near_lim;
  logic                      near_peak;
  logic                      near_now;
  logic                      no_device;

  function automatic logic [MAG_W-1:0] abs_mag(input logic signed [DIFF_W-1:0] d);
    logic signed [DIFF_W-1:0] n;
    n = d[DIFF_W-1] ? -d : d;
    return n[MAG_W-1:0];
  endfunction

  // Ramp step with saturation at full scale.
  assign target_sum = {1'b0, target_now} + {1'b0, cfg.ramp_step};
  assign target_sat = target_sum[VOLT_W] ? '1 : target_sum[VOLT_W-1:0];

  // Sample counter decrement that stops at zero.
  assign samples_dec = (samples_left != '0) ? samples_left - COUNT_W'(1) : samples_left;

  // Short check: distance to the short level, in percent, against the tolerance.
  assign level_s     = $signed({{(DIFF_W-LVL_W){1'b0}}, cfg.short_current_level});
  assign peak_diff   = $signed({{(DIFF_W-CUR_W){peak_current[CUR_W-1]}}, peak_current})
                       - level_s;
  assign cur_diff    = $signed({{(DIFF_W-CUR_W){item.sample_current[CUR_W-1]}},
                                item.sample_current}) - level_s;
  assign peak_scaled = CMP_W'(abs_mag(peak_diff)) * CMP_W'(NEAR_SCALE);
  assign cur_scaled  = CMP_W'(abs_mag(cur_diff)) * CMP_W'(NEAR_SCALE);
  assign near_lim    = LIM_W'(SHORT_TOLERANCE_PERCENT) * LIM_W'(cfg.short_current_level);
  assign near_peak   = peak_scaled < CMP_W'(near_lim);
  assign near_now    = cur_scaled < CMP_W'(near_lim);

  // Missing device: twice the peak stays below the short level.
  assign no_device = $signed({peak_current, 1'b0}) <
                     $signed({2'b00, cfg.short_current_level});

  // Next state of the run for one accepted beat.
  always_comb begin
    running_next        = running;
    plateau_next        = plateau_flag;
    device_checked_next = device_checked;
    sync_pending_next   = sync_pending;
    sync_level_next     = sync_level;
    short_held_next     = short_held;
    target_next         = target_now;
    samples_next        = samples_left;
    samples_seen_next   = samples_seen;
    delay_next          = delay_left;
    stall_next          = stall_ms;
    peak_next           = peak_current;
    status_next         = status;
    check_ok            = 1'b1;
    sync_ok             = 1'b1;
    if (step_en) begin
      if (item.command == CMD_START) begin
        running_next        = 1'b1;
        plateau_next        = 1'b0;
        device_checked_next = 1'b0;
        sync_pending_next   = 1'b0;
        sync_level_next     = 1'b0;
        short_held_next     = 1'b1;
        target_next         = '0;
        samples_next        = cfg.sample_total;
        samples_seen_next   = '0;
        delay_next          = cfg.sync_delay_ticks;
        stall_next          = '0;
        peak_next           = '0;
        status_next         = ST_RUN;
      end else if (running) begin
        if (item.sync_event) begin
          sync_pending_next = 1'b1;
        end
        // Ramp toward the set voltage, then hold the plateau.
        if (target_now < cfg.set_voltage) begin
          target_next  = target_sat;
          plateau_next = 1'b0;
        end else begin
          target_next  = cfg.set_voltage;
          plateau_next = 1'b1;
        end
        // Peak tracking while ramping, device check on the first plateau beat.
        if (!plateau_next) begin
          device_checked_next = 1'b0;
          if (item.sample_current > peak_current) begin
            peak_next = item.sample_current;
          end
        end else if (!device_checked) begin
          device_checked_next = 1'b1;
          peak_next           = '0;
          if (near_peak && near_now) begin
            check_ok     = 1'b0;
            running_next = 1'b0;
            plateau_next = 1'b0;
            status_next  = ST_SHORT;
          end else if (no_device && cfg.device_check_enable) begin
            check_ok     = 1'b0;
            running_next = 1'b0;
            plateau_next = 1'b0;
            status_next  = ST_NODEV;
          end else begin
            short_held_next = 1'b0;
          end
        end
        // Sample counting, sync pulse timing and stall watchdog.
        if (check_ok) begin
          if (!plateau_next) begin
            samples_seen_next = '0;
            delay_next        = cfg.sync_delay_ticks;
            sync_level_next   = 1'b0;
            stall_next        = '0;
          end else if (cfg.emulated_partner) begin
            samples_next = samples_dec;
          end else begin
            if (delay_left != '0) begin
              delay_next = delay_left - COUNT_W'(1);
              if (delay_left == COUNT_W'(1)) begin
                sync_pending_next = 1'b0;
                sync_level_next   = 1'b1;
              end
            end else begin
              if (sync_pending_next) begin
                samples_next = samples_dec;
                delay_next   = cfg.sync_delay_ticks;
              end
              sync_level_next = 1'b0;
            end
            if (samples_seen != samples_next) begin
              samples_seen_next = samples_next;
              stall_next        = '0;
            end else if (item.ms_strobe) begin
              if (stall_ms >= cfg.sync_timeout_ms) begin
                sync_ok      = 1'b0;
                running_next = 1'b0;
                plateau_next = 1'b0;
                status_next  = ST_TIMEOUT;
              end else begin
                stall_next = stall_ms + COUNT_W'(1);
              end
            end
          end
          if (sync_ok && plateau_next && (samples_next == '0)) begin
            running_next = 1'b0;
            plateau_next = 1'b0;
            status_next  = ST_DONE;
          end
        end
      end
    end
  end

  // State registers; all of them are visible through the result, so all reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      running        <= 1'b0;
      plateau_flag   <= 1'b0;
      device_checked <= 1'b0;
      sync_pending   <= 1'b0;
      sync_level     <= 1'b0;
      short_held     <= 1'b0;
      target_now     <= '0;
      samples_left   <= '0;
      samples_seen   <= '0;
      delay_left     <= '0;
      stall_ms       <= '0;
      peak_current   <= '0;
      status         <= ST_IDLE;
    end else begin
      running        <= running_next;
      plateau_flag   <= plateau_next;
      device_checked <= device_checked_next;
      sync_pending   <= sync_pending_next;
      sync_level     <= sync_level_next;
      short_held     <= short_held_next;
      target_now     <= target_next;
      samples_left   <= samples_next;
      samples_seen   <= samples_seen_next;
      delay_left     <= delay_next;
      stall_ms       <= stall_next;
      peak_current   <= peak_next;
      status         <= status_next;
    end
  end

  // The result carries the state after this beat.
  always_comb begin
    res.voltage_target = target_next;
    res.on_plateau     = plateau_next;
    res.sync_out       = sync_level_next;
    res.input_shorted  = short_held_next;
    res.run_status     = status_next;
  end

  `LTS_ASSERT_NOW(a_plateau_only_running, clk, rst, !running, !plateau_flag,
    "plateau flag set while no run is active")
  `LTS_ASSERT_NOW(a_running_status, clk, rst, running, status == ST_RUN,
    "active run does not report running status")
  `LTS_ASSERT_NEXT(a_start_arms, clk, rst, step_en && (item.command == CMD_START),
    running && short_held && (target_now == '0) && !plateau_flag,
    "start beat did not arm a fresh run")

endmodule

FILE: rtl/core/leakage_test_ramp_sequencer.sv
// Top level of the leakage test ramp sequencer: config, beat pipeline and run engine.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+--------------------------------------
//   in       | input     | in_valid/in_ready   | command, sample_current, sync_event,
//            |           |                     | ms_strobe
//   out      | output    | out_valid/out_ready | voltage_target, on_plateau, sync_out,
//            |           |                     | input_shorted, run_status
//   cfg      | input     | cfg_write           | cfg_index, cfg_data
//
// One beat per clock is sustained while out_ready stays high; a result passes the input
// register, then the run update into the result register.
// The run update is a single pass of compare, add and count logic on the state.
// Reset is synchronous: it clears the pipeline, the run state and the config registers.
// A low out_ready holds the result register; the input register still takes one beat,
// after which in_ready drops until the result is taken.
module leakage_test_ramp_sequencer
  import lts_pkg::*;
#(
  parameter int SHORT_TOLERANCE_PERCENT = SHORT_TOLERANCE_PERCENT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        command,
  input  logic signed [CUR_W-1:0]     sample_current,
  input  logic                        sync_event,
  input  logic                        ms_strobe,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [VOLT_W-1:0]           voltage_target,
  output logic                        on_plateau,
  output logic                        sync_out,
  output logic                        input_shorted,
  output logic [2:0]                  run_status,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data
);

  `include "leakage_test_ramp_sequencer_defines.svh"

  cfg_t    cfg;
  item_t   in_item;
  logic    s1_valid;
  logic    advance;
  result_t res;
  result_t out_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_voltage         <= SET_VOLTAGE_RST;
      cfg.ramp_step           <= RAMP_STEP_RST;
      cfg.sample_total        <= SAMPLE_TOTAL_RST;
      cfg.short_current_level <= SHORT_LEVEL_RST;
      cfg.device_check_enable <= 1'b1;
      cfg.emulated_partner    <= 1'b0;
      cfg.sync_delay_ticks    <= SYNC_DELAY_RST;
      cfg.sync_timeout_ms     <= SYNC_TIMEOUT_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SET_VOLTAGE:  cfg.set_voltage         <= cfg_data;
        CFG_RAMP_STEP:    cfg.ramp_step           <= cfg_data;
        CFG_SAMPLE_TOTAL: cfg.sample_total        <= cfg_data;
        CFG_SHORT_LEVEL:  cfg.short_current_level <= cfg_data[LVL_W-1:0];
        CFG_DEV_CHECK_EN: cfg.device_check_enable <= cfg_data[0];
        CFG_EMULATED:     cfg.emulated_partner    <= cfg_data[0];
        CFG_SYNC_DELAY:   cfg.sync_delay_ticks    <= cfg_data;
        CFG_SYNC_TIMEOUT: cfg.sync_timeout_ms     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Beat moves into the engine when the result register is free or being drained.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item.command        <= command;
      in_item.sample_current <= sample_current;
      in_item.sync_event     <= sync_event;
      in_item.ms_strobe      <= ms_strobe;
    end
  end

  lts_engine #(
    .SHORT_TOLERANCE_PERCENT(SHORT_TOLERANCE_PERCENT)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .item    (in_item),
    .cfg     (cfg),
    .res     (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign voltage_target = out_res.voltage_target;
  assign on_plateau     = out_res.on_plateau;
  assign sync_out       = out_res.sync_out;
  assign input_shorted  = out_res.input_shorted;
  assign run_status     = out_res.run_status;

  `LTS_ASSERT_NOW(a_result_from_pipe, clk, rst, $rose(out_valid), $past(s1_valid),
    "result appeared without a beat in the input register")
  `LTS_ASSERT_NEXT(a_stall_holds_input, clk, rst, s1_valid && out_valid && !out_ready,
    s1_valid && $stable(in_item),
    "input register lost its beat while the result stalled")
  `LTS_ASSERT_NEXT(a_stall_holds_result, clk, rst, out_valid && !out_ready,
    out_valid && $stable(out_res),
    "result beat changed while the receiver stalled")

endmodule

FILE: verif/tb_leakage_test_ramp_sequencer.sv
// Self-checking testbench of the leakage test ramp sequencer: random beats against a predictor.
module tb_leakage_test_ramp_sequencer
  import lts_pkg::*;
();

  localparam int ITEM_TARGET    = 1150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_LIMIT    = 40;

  // Scoreboard: mirrors the registers and the run state, predicts one result per input beat.
  class run_scoreboard;
    cfg_t      regs;
    result_t   predicted_results[$];
    int        mismatches;
    bit        running, at_plateau, device_checked, sync_pending, sync_level, short_held;
    bit [15:0] target, samples_left, samples_seen, delay_left;
    int        stall_ms, peak;
    status_t   status;

    function new();
      regs.set_voltage         = SET_VOLTAGE_RST;
      regs.ramp_step           = RAMP_STEP_RST;
      regs.sample_total        = SAMPLE_TOTAL_RST;
      regs.short_current_level = SHORT_LEVEL_RST;
      regs.device_check_enable = 1'b1;
      regs.emulated_partner    = 1'b0;
      regs.sync_delay_ticks    = SYNC_DELAY_RST;
      regs.sync_timeout_ms     = SYNC_TIMEOUT_RST;
      status = ST_IDLE;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [15:0] v);
      case (idx)
        CFG_SET_VOLTAGE:  regs.set_voltage = v;
        CFG_RAMP_STEP:    regs.ramp_step = v;
        CFG_SAMPLE_TOTAL: regs.sample_total = v;
        CFG_SHORT_LEVEL:  regs.short_current_level = v[14:0];
        CFG_DEV_CHECK_EN: regs.device_check_enable = v[0];
        CFG_EMULATED:     regs.emulated_partner = v[0];
        CFG_SYNC_DELAY:   regs.sync_delay_ticks = v;
        CFG_SYNC_TIMEOUT: regs.sync_timeout_ms = v;
        default: ;
      endcase
    endfunction

    function void stop_run(status_t why);
      running = 1'b0;
      at_plateau = 1'b0;
      status = why;
    endfunction

    // Peak tracking while ramping, and the one device check on the first plateau tick.
    function bit check_device(int cur);
      int lvl, lim, d_peak, d_now;
      bit no_dev;
      lvl = int'(regs.short_current_level);
      if (!at_plateau) begin
        device_checked = 1'b0;
        if (cur > peak) peak = cur;
        return 1'b1;
      end
      if (device_checked) return 1'b1;
      device_checked = 1'b1;
      lim = SHORT_TOLERANCE_PERCENT_DEF * lvl;
      d_peak = (peak - lvl < 0) ? lvl - peak : peak - lvl;
      d_now = (cur - lvl < 0) ? lvl - cur : cur - lvl;
      no_dev = (2 * peak < lvl);
      peak = 0;
      if (d_peak * NEAR_SCALE < lim && d_now * NEAR_SCALE < lim) begin
        stop_run(ST_SHORT);
        return 1'b0;
      end
      if (no_dev && regs.device_check_enable) begin
        stop_run(ST_NODEV);
        return 1'b0;
      end
      short_held = 1'b0;
      return 1'b1;
    endfunction

    // Sample counting on the plateau: delayed sync pulses, or one sample per tick when emulated.
    function bit step_sync(bit ms);
      if (!at_plateau) begin
        samples_seen = '0;
        delay_left = regs.sync_delay_ticks;
        sync_level = 1'b0;
        stall_ms = 0;
        return 1'b1;
      end
      if (regs.emulated_partner) begin
        if (samples_left != 0) samples_left--;
        return 1'b1;
      end
      if (delay_left != 0) begin
        delay_left--;
        if (delay_left == 0) begin
          sync_pending = 1'b0;
          sync_level = 1'b1;
        end
      end else begin
        if (sync_pending) begin
          if (samples_left != 0) samples_left--;
          delay_left = regs.sync_delay_ticks;
        end
        sync_level = 1'b0;
      end
      // Stall timer: restarts on progress, otherwise counts milliseconds.
      if (samples_seen != samples_left) begin
        samples_seen = samples_left;
        stall_ms = 0;
      end else if (ms) begin
        if (stall_ms >= int'(regs.sync_timeout_ms)) begin
          stop_run(ST_TIMEOUT);
          return 1'b0;
        end
        stall_ms++;
      end
      return 1'b1;
    endfunction

    function result_t advance_run(logic cmd, logic signed [CUR_W-1:0] cur_in, bit ev, bit ms);
      result_t    r;
      int         cur;
      logic [16:0] sum;
      bit         go_on;
      cur = cur_in;
      if (cmd == CMD_START) begin
        running = 1'b1;
        at_plateau = 1'b0;
        device_checked = 1'b0;
        sync_pending = 1'b0;
        sync_level = 1'b0;
        short_held = 1'b1;
        target = '0;
        samples_left = regs.sample_total;
        samples_seen = '0;
        delay_left = regs.sync_delay_ticks;
        stall_ms = 0;
        peak = 0;
        status = ST_RUN;
      end else if (running) begin
        if (ev) sync_pending = 1'b1;
        // Ramp up with saturation, or hold the set voltage on the plateau.
        if (target < regs.set_voltage) begin
          sum = {1'b0, target} + {1'b0, regs.ramp_step};
          target = sum[16] ? 16'hFFFF : sum[15:0];
          at_plateau = 1'b0;
        end else begin
          target = regs.set_voltage;
          at_plateau = 1'b1;
        end
        go_on = check_device(cur);
        if (go_on) go_on = step_sync(ms);
        if (go_on && at_plateau && samples_left == 0) stop_run(ST_DONE);
      end
      r.voltage_target = target;
      r.on_plateau = at_plateau;
      r.sync_out = sync_level;
      r.input_shorted = short_held;
      r.run_status = status;
      return r;
    endfunction

    function void note_beat(logic cmd, logic signed [CUR_W-1:0] cur, bit ev, bit ms);
      predicted_results.push_back(advance_run(cmd, cur, ev, ms));
    endfunction

    function int pending();
      return predicted_results.size();
    endfunction

    task report_mismatch(string msg);
      if (mismatches < PRINT_LIMIT) $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_result(logic [VOLT_W-1:0] vt, logic plat, logic so, logic sh, logic [2:0] st);
      result_t want;
      if (predicted_results.size() == 0) begin
        report_mismatch("result beat with no prediction waiting");
        return;
      end
      want = predicted_results.pop_front();
      if (vt !== want.voltage_target)
        report_mismatch($sformatf("voltage_target got %0d, expected %0d", vt, want.voltage_target));
      if (plat !== want.on_plateau)
        report_mismatch($sformatf("on_plateau got %b, expected %b", plat, want.on_plateau));
      if (so !== want.sync_out)
        report_mismatch($sformatf("sync_out got %b, expected %b", so, want.sync_out));
      if (sh !== want.input_shorted)
        report_mismatch($sformatf("input_shorted got %b, expected %b", sh, want.input_shorted));
      if (st !== want.run_status)
        report_mismatch($sformatf("run_status got %0d, expected %0d", st, want.run_status));
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     command = CMD_TICK;
  logic signed [CUR_W-1:0]  sample_current = '0;
  logic                     sync_event = 1'b0;
  logic                     ms_strobe = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b1;
  logic [VOLT_W-1:0]        voltage_target;
  logic                     on_plateau;
  logic                     sync_out;
  logic                     input_shorted;
  logic [2:0]               run_status;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;

  run_scoreboard sb;
  int            beats_sent = 0;
  int            quiet_cycles = 0;
  bit            steady_flow = 1'b0;

  leakage_test_ramp_sequencer i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .sample_current(sample_current),
    .sync_event(sync_event), .ms_strobe(ms_strobe),
    .out_valid(out_valid), .out_ready(out_ready),
    .voltage_target(voltage_target), .on_plateau(on_plateau), .sync_out(sync_out),
    .input_shorted(input_shorted), .run_status(run_status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Beat monitors on both channels, plus the count of cycles without any beat.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_beat(command, sample_current, sync_event, ms_strobe);
    if (!rst && out_valid && out_ready)
      sb.check_result(voltage_target, on_plateau, sync_out, input_shorted, run_status);
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // Mostly no gap, some short ones and a few long ones; no gap at all in steady flow.
  function automatic int pick_gap();
    int roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Receiver pacing: runs of ready cycles broken by random stalls.
  initial begin : ready_pacing
    int stall;
    forever begin
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Timeout: the run ends when no beat moves for too long.
  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_beat(logic cmd, int cur, bit ev, bit ms);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    sample_current <= cur[15:0];
    sync_event <= ev;
    ms_strobe <= ms;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Every beat yields one result, so an empty prediction queue means the block is idle;
  // the extra cycles cover the two-stage pipeline.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(cfg_reg_t idx, int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    @(posedge clk);
    sb.write_reg(idx, val[15:0]);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(int unsigned sv, int unsigned rs, int unsigned st,
                             int unsigned lvl, int unsigned en, int unsigned emu,
                             int unsigned dly, int unsigned tmo);
    wait_idle();
    set_reg(CFG_SET_VOLTAGE, sv);
    set_reg(CFG_RAMP_STEP, rs);
    set_reg(CFG_SAMPLE_TOTAL, st);
    set_reg(CFG_SHORT_LEVEL, lvl);
    set_reg(CFG_DEV_CHECK_EN, en);
    set_reg(CFG_EMULATED, emu);
    set_reg(CFG_SYNC_DELAY, dly);
    set_reg(CFG_SYNC_TIMEOUT, tmo);
  endtask

  task automatic directed_checks();
    // Reset settings: idle tick, then zero set voltage makes the first tick a plateau
    // with a zero peak, which is a missing device.
    send_beat(CMD_TICK, 32767, 1'b1, 1'b1);
    send_beat(CMD_START, -32768, 1'b1, 1'b1);
    send_beat(CMD_TICK, -32768, 1'b0, 1'b0);

    // Target saturation at full scale, device released, one delayed sync pulse and finish;
    // then a start while a run is in progress.
    load_config(65535, 40000, 1, 1000, 1, 0, 1, 1);
    send_beat(CMD_START, 0, 1'b0, 1'b0);
    send_beat(CMD_TICK, -1, 1'b1, 1'b0);
    send_beat(CMD_TICK, 32767, 1'b0, 1'b0);
    send_beat(CMD_TICK, 0, 1'b0, 1'b1);
    send_beat(CMD_TICK, 0, 1'b1, 1'b1);
    send_beat(CMD_START, 0, 1'b0, 1'b0);
    send_beat(CMD_TICK, 5, 1'b0, 1'b0);
    send_beat(CMD_START, 0, 1'b0, 1'b0);

    // Peak and present current within tolerance of the short level.
    load_config(100, 100, 65535, 1000, 1, 0, 0, 1);
    send_beat(CMD_START, 0, 1'b0, 1'b0);
    send_beat(CMD_TICK, 1050, 1'b0, 1'b0);
    send_beat(CMD_TICK, 950, 1'b0, 1'b0);

    // Zero ramp step: the target never rises.
    load_config(10, 0, 1, 32767, 0, 0, 25, 100);
    send_beat(CMD_START, 0, 1'b0, 1'b0);
    send_beat(CMD_TICK, 100, 1'b1, 1'b1);
    send_beat(CMD_TICK, 100, 1'b0, 1'b1);

    // Zero short level with emulated sampling down to the finish.
    load_config(1, 1, 2, 0, 1, 1, 25, 100);
    send_beat(CMD_START, 0, 1'b0, 1'b0);
    send_beat(CMD_TICK, -5, 1'b0, 1'b0);
    send_beat(CMD_TICK, 0, 1'b0, 1'b0);
    send_beat(CMD_TICK, 0, 1'b0, 1'b0);

    // Zero sync delay with no events: the stall timer runs out.
    load_config(0, 1, 3, 100, 0, 0, 0, 1);
    send_beat(CMD_START, 0, 1'b0, 1'b0);
    send_beat(CMD_TICK, 0, 1'b0, 1'b1);
    send_beat(CMD_TICK, 0, 1'b0, 1'b1);
    send_beat(CMD_TICK, 0, 1'b0, 1'b1);
  endtask

  // Settings biased toward short ramps and small sample counts, with the extremes mixed in.
  task automatic random_config();
    int unsigned sv, rs, st, lvl, dly, tmo;
    case ($urandom_range(0, 9))
      0: begin
        sv = 65535;
        rs = $urandom_range(0, 1) ? 65535 : $urandom_range(20000, 40000);
      end
      1: begin
        sv = $urandom_range(0, 3);
        rs = $urandom_range(0, 3);
      end
      default: begin
        sv = $urandom_range(0, 3000);
        rs = $urandom_range(150, 1500);
      end
    endcase
    st = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(0, 6);
    case ($urandom_range(0, 19))
      0, 1: lvl = 32767;
      2, 3: lvl = 1;
      4:    lvl = 0;
      default: lvl = $urandom_range(50, 32767);
    endcase
    case ($urandom_range(0, 19))
      0, 1: dly = 0;
      2:    dly = 65535;
      default: dly = $urandom_range(1, 5);
    endcase
    tmo = ($urandom_range(0, 11) == 0) ? 65535 : $urandom_range(1, 20);
    load_config(sv, rs, st, lvl, ($urandom_range(0, 3) != 0), ($urandom_range(0, 3) == 0),
                dly, tmo);
  endtask

  // Current of one tick for the device behavior picked for this run.
  function automatic int run_current(int kind, int lvl);
    int pct, jitter, cur;
    if (kind >= 9) begin
      if ($urandom_range(0, 3) == 0) return -int'($urandom_range(0, 32768));
      pct = $urandom_range(0, 45);
    end else if (kind >= 7) begin
      pct = $urandom_range(92, 108);
    end else if ($urandom_range(0, 4) == 0) begin
      pct = $urandom_range(112, 150);
    end else begin
      pct = $urandom_range(52, 88);
    end
    jitter = $urandom_range(0, 4);
    cur = lvl * pct / 100 + jitter - 2;
    if (cur > 32767) cur = 32767;
    if (cur < -32768) cur = -32768;
    return cur;
  endfunction

  // One run: a start and a train of ticks, or a short burst of fully random beats.
  task automatic random_run();
    int kind, lvl, ev_pct, ms_pct;
    kind = $urandom_range(0, 11);
    lvl = int'(sb.regs.short_current_level);
    if (kind == 11) begin
      repeat ($urandom_range(1, 6))
        send_beat(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    end else begin
      ev_pct = $urandom_range(0, 60);
      ms_pct = $urandom_range(5, 70);
      if ($urandom_range(0, 19) != 0)
        send_beat(CMD_START, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(3, 45)) begin
        if ($urandom_range(0, 99) == 0)
          send_beat(CMD_START, $urandom, 1'b0, 1'b0);
        else
          send_beat(CMD_TICK, run_current(kind, lvl), ($urandom_range(0, 99) < ev_pct),
                    ($urandom_range(0, 99) < ms_pct));
      end
    end
  endtask

  initial begin : main_flow
    int phase_end;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_checks();
    while (beats_sent < ITEM_TARGET) begin
      random_config();
      steady_flow = ($urandom_range(0, 3) == 0);
      phase_end = beats_sent + $urandom_range(60, 120);
      while (beats_sent < phase_end) random_run();
    end
    wait_idle();
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d predicted results never arrived", sb.pending()));
    if (sb.mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/lts_pkg.sv
rtl/core/lts_engine.sv
rtl/core/leakage_test_ramp_sequencer.sv
verif/tb_leakage_test_ramp_sequencer.sv
